// ----- rtl/core/bdr_pkg.sv -----
// Package for the buck duty ramp core: beat types, register indexes and
// ramp constants. No dependencies.
package bdr_pkg;

    localparam int RatioW = 16;

    localparam logic [RatioW-1:0] RampUpStep    = 16'd4;
    localparam logic [RatioW-1:0] RampDownStep  = 16'd983;
    localparam logic [RatioW-1:0] PresentMargin = 16'd9830;

    typedef enum logic [1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_RANGE = 2'd1,
        FAULT_OVERV = 2'd2,
        FAULT_OVERC = 2'd3
    } t_fault;

    typedef enum logic [2:0] {
        REG_CURRENT_LIMIT  = 3'd0,
        REG_SUPPLY_MIN     = 3'd1,
        REG_SUPPLY_MAX     = 3'd2,
        REG_OUTPUT_LIMIT   = 3'd3,
        REG_RATIO_CEILING  = 3'd4,
        REG_PWM_FULL_SCALE = 3'd5,
        REG_READY_LEVEL    = 3'd6,
        REG_LOW_OUTPUT     = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] supply_volts;
        logic [15:0] output_volts;
        logic [15:0] output_amps;
        logic [15:0] present_ratio;
        logic [15:0] target_ratio;
        logic        start_request;
        logic        fault_clear;
        logic        upstream_inhibit;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] compare_value;
        logic        outputs_forced_low;
        logic        deadband_on;
        logic        trip_force;
        logic        ready_res;
        logic [1:0]  fault_code;
        logic        inhibited;
        logic        inhibit_downstream;
    } t_out_beat;

    // controller state after one tick, handed to the compare stage
    typedef struct packed {
        logic [RatioW-1:0] duty;
        logic              running;
        logic              trip;
        logic              ready;
        t_fault            fault;
        logic              inhibit;
        logic              inhibit_dn;
    } t_stage;

endpackage

// ----- rtl/core/bdr_pwm.sv -----
// Compare stage: full_scale * (1 - duty) and the result register.
// Depends on bdr_pkg.
module bdr_pwm (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  bdr_pkg::t_stage   i_stage,
    input  logic [15:0]       i_full_scale,
    output logic              o_valid,
    input  logic              i_ready,
    output bdr_pkg::t_out_beat o_beat
);
    import bdr_pkg::*;

    logic              r_valid;
    logic              n_valid;
    t_out_beat         r_beat;
    t_out_beat         n_beat;
    logic [16:0]       w_span;
    logic [32:0]       w_prod;

    assign o_ready = !r_valid || i_ready;

    assign w_span = 17'h10000 - {1'b0, i_stage.duty};
    assign w_prod = {17'd0, i_full_scale} * {16'd0, w_span};

    always_comb begin
        n_beat                    = r_beat;
        n_valid                   = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
        if (i_valid && o_ready) begin
            n_beat.compare_value      = w_prod[31:16];
            n_beat.outputs_forced_low = !i_stage.running;
            n_beat.deadband_on        = i_stage.running;
            n_beat.trip_force         = i_stage.trip;
            n_beat.ready_res          = i_stage.ready;
            n_beat.fault_code         = i_stage.fault;
            n_beat.inhibited          = i_stage.inhibit;
            n_beat.inhibit_downstream = i_stage.inhibit_dn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_beat <= n_beat;
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// ----- rtl/core/buck_duty_ramp_with_fault_latch_core.sv -----
// Top level of the buck duty ramp core: configuration registers, fault and
// inhibit latches, duty ramp. Depends on bdr_pkg and bdr_pwm.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in) takes one control tick per
//   beat: measurements, present and target ratio, start, clear and inhibit.
//   Output channel (o_out_valid / i_out_ready / o_out) gives one result beat
//   per input beat, in order.
//   Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data);
//   write only while no beat is in flight.
//   A beat passes the state stage register, then the result register to o_out.
//   Throughput: one beat per cycle while i_out_ready is high. Latches and duty
//   update in the cycle of acceptance, the compare multiply in the second stage.
//   Reset: latches clear, stopped, duty zero, registers at their defaults,
//   no beats held.
//   Receiver stall: the result register holds; the state stage holds one more
//   beat, then o_in_ready drops until the output drains.
module buck_duty_ramp_with_fault_latch_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bdr_pkg::t_in_beat  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bdr_pkg::t_out_beat o_out
);
    import bdr_pkg::*;

    logic [15:0] r_current_limit;
    logic [15:0] r_supply_min;
    logic [15:0] r_supply_max;
    logic [15:0] r_output_limit;
    logic [15:0] r_ratio_ceiling;
    logic [15:0] r_full_scale;
    logic [15:0] r_ready_level;
    logic [15:0] r_low_output;

    t_stage      r_stage;
    t_stage      n_stage;
    logic        r_a_valid;
    logic        n_a_valid;
    logic        w_pwm_ready;
    logic        w_accept;

    t_fault      w_fault;
    logic        w_inhibit;
    logic        w_trip;
    logic        w_run;
    logic signed [17:0] w_diff;
    logic signed [17:0] w_next;
    logic [16:0] w_cap_wide;
    logic [16:0] w_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current_limit <= 16'hFFFF;
            r_supply_min    <= 16'd0;
            r_supply_max    <= 16'hFFFF;
            r_output_limit  <= 16'hFFFF;
            r_ratio_ceiling <= 16'h8000;
            r_full_scale    <= 16'd0;
            r_ready_level   <= 16'd2688;
            r_low_output    <= 16'd2048;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_CURRENT_LIMIT:  r_current_limit <= i_cfg_data;
                REG_SUPPLY_MIN:     r_supply_min    <= i_cfg_data;
                REG_SUPPLY_MAX:     r_supply_max    <= i_cfg_data;
                REG_OUTPUT_LIMIT:   r_output_limit  <= i_cfg_data;
                REG_RATIO_CEILING:  r_ratio_ceiling <= i_cfg_data;
                REG_PWM_FULL_SCALE: r_full_scale    <= i_cfg_data;
                REG_READY_LEVEL:    r_ready_level   <= i_cfg_data;
                REG_LOW_OUTPUT:     r_low_output    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_ready = !r_a_valid || w_pwm_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // fault priority: overcurrent, input range, overvoltage; clear applies only when none is present
    always_comb begin
        if (i_in.output_amps > r_current_limit) begin
            w_fault = FAULT_OVERC;
        end else if (i_in.supply_volts < r_supply_min ||
                     i_in.supply_volts > r_supply_max) begin
            w_fault = FAULT_RANGE;
        end else if (i_in.output_volts > r_output_limit) begin
            w_fault = FAULT_OVERV;
        end else if (i_in.fault_clear) begin
            w_fault = FAULT_NONE;
        end else begin
            w_fault = r_stage.fault;
        end
    end

    assign w_inhibit = i_in.upstream_inhibit || (!i_in.fault_clear && r_stage.inhibit);
    assign w_trip    = (w_fault != FAULT_NONE) || w_inhibit;
    assign w_run     = (i_in.start_request || r_stage.running) && !w_trip;

    // ramp step clamp, then cap at min(present + margin, ceiling), floor at zero
    always_comb begin
        w_diff = $signed({2'b00, i_in.target_ratio}) - $signed({2'b00, r_stage.duty});
        if (w_diff < -$signed({2'b00, RampDownStep})) begin
            w_diff = -$signed({2'b00, RampDownStep});
        end
        if (w_diff > $signed({2'b00, RampUpStep})) begin
            w_diff = $signed({2'b00, RampUpStep});
        end
        w_cap_wide = {1'b0, i_in.present_ratio} + {1'b0, PresentMargin};
        w_cap      = (w_cap_wide > {1'b0, r_ratio_ceiling}) ? {1'b0, r_ratio_ceiling}
                                                            : w_cap_wide;
        w_next = $signed({2'b00, r_stage.duty}) + w_diff;
        if (w_next > $signed({1'b0, w_cap})) begin
            w_next = $signed({1'b0, w_cap});
        end
        if (w_next < 18'sd0) begin
            w_next = 18'sd0;
        end
    end

    always_comb begin
        n_stage   = r_stage;
        n_a_valid = r_a_valid;
        if (w_pwm_ready) begin
            n_a_valid = 1'b0;
        end
        if (w_accept) begin
            n_a_valid          = 1'b1;
            n_stage.fault      = w_fault;
            n_stage.inhibit    = w_inhibit;
            n_stage.trip       = w_trip;
            n_stage.running    = w_run;
            if (w_run) begin
                n_stage.duty       = w_next[15:0];
                n_stage.ready      = i_in.output_volts > r_ready_level;
                n_stage.inhibit_dn = i_in.output_volts < r_low_output;
            end else begin
                n_stage.duty       = i_in.present_ratio;
                n_stage.ready      = 1'b0;
                n_stage.inhibit_dn = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_stage   <= '0;
        end else begin
            r_a_valid <= n_a_valid;
            r_stage   <= n_stage;
        end
    end

    bdr_pwm u_pwm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_a_valid),
        .o_ready      (w_pwm_ready),
        .i_stage      (r_stage),
        .i_full_scale (r_full_scale),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_beat       (o_out)
    );

    a_run_no_trip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stage.running |-> !r_stage.trip)
        else $error("running with trip set");

    a_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !i_in.fault_clear && r_stage.fault != FAULT_NONE
        |=> r_stage.fault != FAULT_NONE)
        else $error("fault code lost without clear");

    a_inhibit_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_in.upstream_inhibit |=> r_stage.inhibit && !r_stage.running)
        else $error("inhibit not latched");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !w_pwm_ready |=> r_a_valid && $stable(r_stage))
        else $error("held state beat changed under stall");

endmodule
